// File: hw/rtl/srms_pkg.sv
`default_nettype none

package srms_pkg;

  localparam int unsigned SAMPLES  = 5;
  localparam int unsigned SMP_IW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SMP_CW   = $clog2(SAMPLES + 1);
  localparam int unsigned MED_RANK = SAMPLES / 2;

  localparam int unsigned DIST_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;

  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST   = 8'd30;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST   = 8'd150;
  localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 7'd5;
  localparam logic [IVL_W-1:0]   SWEEP_IVL_RST   = 16'd100;
  localparam logic [ANGLE_W-1:0] RIGHT_LIMIT_RST = 8'd80;
  localparam logic [ANGLE_W-1:0] LEFT_LIMIT_RST  = 8'd100;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MIN_ANGLE   = 3'd0,
    CFG_MAX_ANGLE   = 3'd1,
    CFG_STEP_SIZE   = 3'd2,
    CFG_SWEEP_IVL   = 3'd3,
    CFG_RIGHT_LIMIT = 3'd4,
    CFG_LEFT_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SEC_RIGHT  = 2'd0,
    SEC_CENTER = 2'd1,
    SEC_LEFT   = 2'd2
  } sector_e;

  typedef struct packed {
    logic              we;
    logic [SMP_IW-1:0] addr;
    logic [DIST_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] value;
  } med_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/srms_median.sv
`default_nettype none

module srms_median (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srms_pkg::wr_req_t wr_i,
  input  logic             start_i,
  output srms_pkg::med_res_t res_o
);
  import srms_pkg::*;

  logic [DIST_W-1:0] mem [SAMPLES];
  logic [DIST_W-1:0] rda_q, rdb_q;

  logic              busy_q;
  logic [SMP_IW-1:0] i_q;
  logic [SMP_CW-1:0] j_q;
  logic              pend_q, last_q;
  logic [SMP_CW-1:0] lt_q, le_q;

  logic              issue;
  logic [SMP_CW-1:0] lt_n, le_n;
  logic              found;

  assign issue = busy_q && (j_q < SMP_CW'(SAMPLES));
  assign lt_n  = lt_q + SMP_CW'(rdb_q < rda_q);
  assign le_n  = le_q + SMP_CW'(rdb_q <= rda_q);
  // candidate is the median when exactly rank elements can sit below it
  assign found = (lt_n <= SMP_CW'(MED_RANK)) && (le_n > SMP_CW'(MED_RANK));

  assign res_o.valid = last_q && found;
  assign res_o.value = rda_q;

  // port a holds the candidate, port b sweeps all entries
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rda_q <= mem[i_q];
    rdb_q <= mem[j_q[SMP_IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      pend_q <= 1'b0;
      last_q <= 1'b0;
      lt_q   <= '0;
      le_q   <= '0;
    end else begin
      pend_q <= issue;
      last_q <= issue && (j_q == SMP_CW'(SAMPLES - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        j_q    <= '0;
        lt_q   <= '0;
        le_q   <= '0;
      end else begin
        if (issue) begin
          j_q <= j_q + SMP_CW'(1);
        end
        if (last_q && !found) begin
          i_q  <= i_q + SMP_IW'(1);
          j_q  <= '0;
          lt_q <= '0;
          le_q <= '0;
        end else if (pend_q) begin
          lt_q <= lt_n;
          le_q <= le_n;
        end
        if (last_q && found) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sweep_radar_median_sectors_core.sv
// Scanning sonar median filter. Each transfer on the input channel carries one finished
// distance and its millisecond time stamp and yields exactly one result. Distances fill a
// sample memory of SAMPLES entries; the input that fills it triggers a median search over
// that memory (candidate read on one port, all entries swept on the other for each candidate
// tried), the median is filed under the right, centre or left sector by the current angle,
// and, for an item that completed a median, if the sweep interval has elapsed the angle
// steps and reverses at the limits. One item at a time is in flight: an item that does not
// fill the buffer passes from the emit state into the output register, one that fills it
// first waits in the median state for the search, and no new item is taken until its
// result has been emitted. The next item is taken while the previous result still waits
// in the output register. Configuration writes are always ready and must only be issued
// while the block is idle.
`default_nettype none

module sweep_radar_median_sectors_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [srms_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [srms_pkg::CDATA_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [srms_pkg::DIST_W-1:0]  distance_i,
  input  logic [srms_pkg::TIME_W-1:0]  now_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [srms_pkg::ANGLE_W-1:0] angle_o,
  output logic [srms_pkg::DIST_W-1:0]  left_dist_o,
  output logic [srms_pkg::DIST_W-1:0]  center_dist_o,
  output logic [srms_pkg::DIST_W-1:0]  right_dist_o,
  output logic [2:0]                   sector_valid_o,
  output logic                         median_done_o,
  output logic                         moved_o
);
  import srms_pkg::*;

  // configuration
  logic [ANGLE_W-1:0] min_angle_q, max_angle_q, right_limit_q, left_limit_q;
  logic [STEP_W-1:0]  step_q;
  logic [IVL_W-1:0]   interval_q;

  // block state
  state_e             state_q, state_d;
  logic [SMP_IW-1:0]  count_q;
  logic [ANGLE_W-1:0] angle_q;
  logic               up_q;
  logic [TIME_W-1:0]  last_move_q;
  logic [DIST_W-1:0]  right_q, center_q, left_q;
  logic [2:0]         flags_q;

  // current item
  logic [TIME_W-1:0]  now_q;
  logic               done_q;
  logic [DIST_W-1:0]  med_q;

  // output register
  logic               out_valid_q;
  logic [ANGLE_W-1:0] out_angle_q;
  logic [DIST_W-1:0]  out_left_q, out_center_q, out_right_q;
  logic [2:0]         out_flags_q;
  logic               out_done_q, out_moved_q;

  logic               in_xfer, last_sample, med_start, emit_fire, out_free;
  wr_req_t            wr_req;
  med_res_t           med_res;

  logic [TIME_W-1:0]  elapsed;
  logic               step_ok;
  logic signed [9:0]  a_sum;
  logic signed [9:0]  a_clamp;
  logic               up_d;
  logic [ANGLE_W-1:0] angle_d;
  sector_e            slot;
  logic [DIST_W-1:0]  right_d, center_d, left_d;
  logic [2:0]         flags_d;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign last_sample = (count_q == SMP_IW'(SAMPLES - 1));
  assign out_free    = !out_valid_q || !out_stall_i;

  assign wr_req.we   = in_xfer;
  assign wr_req.addr = count_q;
  assign wr_req.data = distance_i;

  srms_median u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_req),
    .start_i (med_start),
    .res_o   (med_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = last_sample ? ST_MEDIAN : ST_EMIT;
        end
      end
      ST_MEDIAN: begin
        if (med_res.valid) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall_o = 1'b1;
    med_start  = 1'b0;
    emit_fire  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        med_start  = in_valid_i && last_sample;
      end
      ST_MEDIAN: ;
      ST_EMIT:   emit_fire = out_free;
      default: ;
    endcase
  end

  // sector and sweep step for the item being emitted
  always_comb begin
    elapsed = now_q - last_move_q;
    step_ok = done_q && (elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval_q});

    if (up_q) begin
      a_sum = $signed({2'b00, angle_q}) + $signed({3'b000, step_q});
    end else begin
      a_sum = $signed({2'b00, angle_q}) - $signed({3'b000, step_q});
    end
    a_clamp = a_sum;
    up_d    = up_q;
    // max limit first, then min, so crossed limits end at min
    if (a_clamp >= $signed({2'b00, max_angle_q})) begin
      a_clamp = $signed({2'b00, max_angle_q});
      up_d    = 1'b0;
    end
    if (a_clamp <= $signed({2'b00, min_angle_q})) begin
      a_clamp = $signed({2'b00, min_angle_q});
      up_d    = 1'b1;
    end
    angle_d = step_ok ? a_clamp[ANGLE_W-1:0] : angle_q;

    if (angle_q < right_limit_q) begin
      slot = SEC_RIGHT;
    end else if (angle_q > left_limit_q) begin
      slot = SEC_LEFT;
    end else begin
      slot = SEC_CENTER;
    end

    right_d  = right_q;
    center_d = center_q;
    left_d   = left_q;
    flags_d  = flags_q;
    if (done_q) begin
      case (slot)
        SEC_RIGHT:  begin
          right_d    = med_q;
          flags_d[0] = 1'b1;
        end
        SEC_CENTER: begin
          center_d   = med_q;
          flags_d[1] = 1'b1;
        end
        SEC_LEFT:   begin
          left_d     = med_q;
          flags_d[2] = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q   <= MIN_ANGLE_RST;
      max_angle_q   <= MAX_ANGLE_RST;
      step_q        <= STEP_SIZE_RST;
      interval_q    <= SWEEP_IVL_RST;
      right_limit_q <= RIGHT_LIMIT_RST;
      left_limit_q  <= LEFT_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_ANGLE:   min_angle_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_MAX_ANGLE:   max_angle_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_STEP_SIZE:   step_q        <= cfg_data_i[STEP_W-1:0];
        CFG_SWEEP_IVL:   interval_q    <= cfg_data_i[IVL_W-1:0];
        CFG_RIGHT_LIMIT: right_limit_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_LEFT_LIMIT:  left_limit_q  <= cfg_data_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      done_q      <= 1'b0;
      angle_q     <= MIN_ANGLE_RST;
      up_q        <= 1'b1;
      last_move_q <= '0;
      right_q     <= '0;
      center_q    <= '0;
      left_q      <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        count_q <= last_sample ? '0 : count_q + SMP_IW'(1);
        done_q  <= last_sample;
      end
      if (emit_fire) begin
        right_q  <= right_d;
        center_q <= center_d;
        left_q   <= left_d;
        flags_q  <= flags_d;
        if (step_ok) begin
          angle_q     <= angle_d;
          up_q        <= up_d;
          last_move_q <= now_q;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q <= now_ms_i;
    end
    if (med_res.valid) begin
      med_q <= med_res.value;
    end
    if (emit_fire) begin
      out_angle_q  <= angle_d;
      out_left_q   <= left_d;
      out_center_q <= center_d;
      out_right_q  <= right_d;
      out_flags_q  <= flags_d;
      out_done_q   <= done_q;
      out_moved_q  <= step_ok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign angle_o        = out_angle_q;
  assign left_dist_o    = out_left_q;
  assign center_dist_o  = out_center_q;
  assign right_dist_o   = out_right_q;
  assign sector_valid_o = out_flags_q;
  assign median_done_o  = out_done_q;
  assign moved_o        = out_moved_q;

  a_med_res_in_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_res.valid |-> state_q == ST_MEDIAN)
    else $error("median result outside median search");

  a_emit_buffer_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && done_q) |-> count_q == '0)
    else $error("sample count not cleared after median");

  a_emit_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_valid_o)
    else $error("emitted result not presented");

  a_move_needs_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!moved_o || median_done_o))
    else $error("angle moved without a median");

endmodule

`default_nettype wire
